>>> src/wca_pkg.sv
// Shared constants, codes and handshake types for the weighted circular autocorrelation block.
package wca_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int RADIUS_BITS_DEF = 18;
  localparam int LAG_W           = 10;
  localparam int EPS_W           = 32;
  localparam int ERR_W           = 2;
  localparam int FRAC_BITS       = 29;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_AVG = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

  localparam logic [EPS_W-1:0] EPS_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [EPS_W-1:0] EPS_NEG_MIN = 32'h8000_0000;
  localparam logic [EPS_W:0]   EPS_NEG_MAG = 33'h0_8000_0000;

  typedef struct packed {
    logic             start;
    logic [LAG_W-1:0] lag;
  } corr_req_t;

  typedef struct packed {
    logic             valid;
    logic [EPS_W-1:0] eps;
  } corr_res_t;

endpackage

>>> src/wca_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
module wca_ram #(
  parameter int Width = 18,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/wca_corr.sv
// Query engine: pipelined multiply-accumulate over the stored set, bit-serial divisor and divider.
module wca_corr import wca_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  corr_req_t                                   req_i,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]            count_i,
  input  logic [RADIUS_BITS+$clog2(3*MAX_SAMPLES)-1:0] sum_i,
  input  logic                                        ack_i,
  output corr_res_t                                   res_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]              raddr_a_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]              raddr_b_o,
  input  logic [RADIUS_BITS-1:0]                      rdata_a_i,
  input  logic [RADIUS_BITS-1:0]                      rdata_b_i
);

  localparam int CW   = $clog2(MAX_SAMPLES+1);
  localparam int IW   = $clog2(MAX_SAMPLES);
  localparam int SW   = RADIUS_BITS + $clog2(3*MAX_SAMPLES);
  localparam int A3W  = $clog2(3*MAX_SAMPLES+1);
  localparam int H    = (SW+1)/2;
  localparam int AW   = 2*SW + 2 + CW + 1;
  localparam int NW   = AW + FRAC_BITS;
  localparam int DENW = 2*SW + A3W;
  localparam int DCW  = $clog2(SW+1);
  localparam int QCW  = $clog2(NW+1);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_LOOP  = 3'd1;
  localparam logic [2:0] C_DRAIN = 3'd2;
  localparam logic [2:0] C_MAG   = 3'd3;
  localparam logic [2:0] C_DIV   = 3'd4;
  localparam logic [2:0] C_ROUND = 3'd5;
  localparam logic [2:0] C_SAT   = 3'd6;
  localparam logic [2:0] C_DONE  = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [A3W-1:0] a3_q;
  logic [IW-1:0]  k_q, idx_q;
  logic           k_last, idx_wrap;
  logic [CW-1:0]  n_m1, jp1;

  // MAC pipeline
  logic              p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  logic              p1_par_q, p2_par_q, p3_par_q, p4_par_q, p5_par_q;
  logic [A3W+RADIUS_BITS-1:0] pa_full, pk_full;
  logic [SW-1:0]     p2_pa_q, p2_pk_q;
  logic [SW:0]       da, dk, da_n, dk_n;
  logic [SW-1:0]     p3_ma_q, p3_mk_q;
  logic              p3_neg_q, p4_neg_q, p5_neg_q;
  logic [2*H-1:0]    ma_x, mk_x;
  logic [2*H-1:0]    pp00, pp01, pp10, pp11;
  logic [2*H-1:0]    p4_pp00_q, p4_pp01_q, p4_pp10_q, p4_pp11_q;
  logic [4*H-1:0]    prod;
  logic [AW-1:0]     pw, p5_p_q, acc_q;

  // divisor: sum^2 * 3n
  logic              den_load_q;
  logic [DCW-1:0]    den_cnt_q;
  logic [SW+A3W-1:0] x_full;
  logic [DENW-1:0]   x_q, den_q;
  logic [SW-1:0]     s_sh_q;
  logic              den_done;

  // divider
  logic              neg_q;
  logic [AW-1:0]     mag;
  logic [NW-1:0]     num_q, q_q;
  logic [DENW-1:0]   rem_q;
  logic [DENW:0]     trial, trial_sub;
  logic              trial_ge;
  logic [QCW-1:0]    div_cnt_q;
  logic [NW:0]       qr_q;
  logic [EPS_W-1:0]  eps_q;

  assign n_m1     = count_i - 1'b1;
  assign jp1      = CW'(req_i.lag) + 1'b1;
  assign k_last   = (CW'(k_q) == n_m1);
  assign idx_wrap = (CW'(idx_q) == n_m1);
  assign den_done = !den_load_q && (den_cnt_q == '0);

  assign raddr_a_o = idx_q;
  assign raddr_b_o = k_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (req_i.start) state_d = C_LOOP;
      C_LOOP:  if (k_last) state_d = C_DRAIN;
      C_DRAIN: begin
        if (!(p1_v_q || p2_v_q || p3_v_q || p4_v_q || p5_v_q) && den_done) begin
          state_d = C_MAG;
        end
      end
      C_MAG:   state_d = C_DIV;
      C_DIV:   if (div_cnt_q == QCW'(1)) state_d = C_ROUND;
      C_ROUND: state_d = C_SAT;
      C_SAT:   state_d = C_DONE;
      C_DONE:  if (ack_i) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= C_IDLE;
      p1_v_q     <= 1'b0;
      p2_v_q     <= 1'b0;
      p3_v_q     <= 1'b0;
      p4_v_q     <= 1'b0;
      p5_v_q     <= 1'b0;
      den_load_q <= 1'b0;
      den_cnt_q  <= '0;
      div_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      p1_v_q     <= (state_q == C_LOOP);
      p2_v_q     <= p1_v_q;
      p3_v_q     <= p2_v_q;
      p4_v_q     <= p3_v_q;
      p5_v_q     <= p4_v_q;
      den_load_q <= (state_q == C_IDLE) && req_i.start;
      if (den_load_q) begin
        den_cnt_q <= DCW'(SW);
      end else if (den_cnt_q != '0) begin
        den_cnt_q <= den_cnt_q - 1'b1;
      end
      if (state_q == C_MAG) begin
        div_cnt_q <= QCW'(NW);
      end else if (state_q == C_DIV) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && req_i.start) begin
      a3_q  <= A3W'(count_i) + (A3W'(count_i) << 1);
      k_q   <= '0;
      idx_q <= (jp1 == count_i) ? '0 : jp1[IW-1:0];
      acc_q <= '0;
    end else begin
      if (state_q == C_LOOP) begin
        k_q   <= k_q + 1'b1;
        idx_q <= idx_wrap ? '0 : idx_q + 1'b1;
      end
      if (p5_v_q) begin
        acc_q <= p5_neg_q ? acc_q - p5_p_q : acc_q + p5_p_q;
      end
    end
  end

  // multiply-accumulate stages
  assign pa_full = a3_q * rdata_a_i;
  assign pk_full = a3_q * rdata_b_i;
  assign da      = {1'b0, p2_pa_q} - {1'b0, sum_i};
  assign dk      = {1'b0, p2_pk_q} - {1'b0, sum_i};
  assign da_n    = '0 - da;
  assign dk_n    = '0 - dk;
  assign ma_x    = (2*H)'(p3_ma_q);
  assign mk_x    = (2*H)'(p3_mk_q);
  assign pp00    = ma_x[H-1:0]   * mk_x[H-1:0];
  assign pp01    = ma_x[H-1:0]   * mk_x[2*H-1:H];
  assign pp10    = ma_x[2*H-1:H] * mk_x[H-1:0];
  assign pp11    = ma_x[2*H-1:H] * mk_x[2*H-1:H];
  assign prod    = (4*H)'(p4_pp00_q) + ((4*H)'(p4_pp01_q) << H)
                 + ((4*H)'(p4_pp10_q) << H) + ((4*H)'(p4_pp11_q) << (2*H));
  assign pw      = p4_par_q ? (AW'(prod[2*SW-1:0]) << 2) : (AW'(prod[2*SW-1:0]) << 1);

  always_ff @(posedge clk_i) begin
    p1_par_q  <= k_q[0];
    p2_par_q  <= p1_par_q;
    p2_pa_q   <= pa_full[SW-1:0];
    p2_pk_q   <= pk_full[SW-1:0];
    p3_par_q  <= p2_par_q;
    p3_ma_q   <= da[SW] ? da_n[SW-1:0] : da[SW-1:0];
    p3_mk_q   <= dk[SW] ? dk_n[SW-1:0] : dk[SW-1:0];
    p3_neg_q  <= da[SW] ^ dk[SW];
    p4_par_q  <= p3_par_q;
    p4_neg_q  <= p3_neg_q;
    p4_pp00_q <= pp00;
    p4_pp01_q <= pp01;
    p4_pp10_q <= pp10;
    p4_pp11_q <= pp11;
    p5_par_q  <= p4_par_q;
    p5_neg_q  <= p4_neg_q;
    p5_p_q    <= pw;
  end

  // shift-add divisor
  assign x_full = sum_i * a3_q;

  always_ff @(posedge clk_i) begin
    if (den_load_q) begin
      x_q    <= DENW'(x_full);
      s_sh_q <= sum_i;
      den_q  <= '0;
    end else if (den_cnt_q != '0) begin
      if (s_sh_q[0]) begin
        den_q <= den_q + x_q;
      end
      x_q    <= x_q << 1;
      s_sh_q <= s_sh_q >> 1;
    end
  end

  // restoring divider, rounding and saturation
  assign mag       = acc_q[AW-1] ? ('0 - acc_q) : acc_q;
  assign trial     = {rem_q, num_q[NW-1]};
  assign trial_ge  = (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_MAG: begin
        neg_q <= acc_q[AW-1];
        num_q <= NW'(mag) << FRAC_BITS;
        rem_q <= '0;
        q_q   <= '0;
      end
      C_DIV: begin
        num_q <= num_q << 1;
        rem_q <= trial_ge ? trial_sub[DENW-1:0] : trial[DENW-1:0];
        q_q   <= {q_q[NW-2:0], trial_ge};
      end
      C_ROUND: begin
        qr_q <= (NW+1)'(q_q) + (({rem_q, 1'b0} >= {1'b0, den_q}) ? 1'b1 : 1'b0);
      end
      C_SAT: begin
        if (neg_q) begin
          eps_q <= (qr_q > (NW+1)'(EPS_NEG_MAG)) ? EPS_NEG_MIN : ('0 - qr_q[EPS_W-1:0]);
        end else begin
          eps_q <= (qr_q > (NW+1)'(EPS_POS_MAX)) ? EPS_POS_MAX : qr_q[EPS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid = (state_q == C_DONE);
  assign res_o.eps   = eps_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == C_IDLE)
    else $error("query started while engine busy");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_LOOP |-> (CW'(idx_q) < count_i) && (CW'(k_q) < count_i))
    else $error("sample address beyond set");
  a_mac_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p5_v_q |-> (state_q == C_LOOP || state_q == C_DRAIN))
    else $error("accumulate outside sample walk");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_DIV |-> rem_q < den_q)
    else $error("partial remainder not below divisor");
  a_den_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_MAG |-> den_done)
    else $error("division started before divisor finished");
`endif

endmodule

>>> src/weighted_circular_autocorrelation.sv
// Top level: sample loading, query dispatch and output register.
// Use: a single input stream carries transactions. tuser = 0 loads the radius in
// tdata into the current set (the first load after a query opens a new set);
// tuser = 1 queries autocorrelation index lag (tdata upper field) of the set.
// Loads give no output; a load beyond MAX_SAMPLES is dropped
// and marks the set as overflowed. Each query gives one output transaction:
// epsilon (signed Q2.29, saturated) in tdata and an error code in tuser.
// A query rejected for range or zero average does not start the engine. The
// sample walk reads one stored pair a cycle through the RAM's two read ports
// into a 5-stage multiply-accumulate pipeline, and the bit-serial divider
// makes one quotient bit a cycle. The input is not ready while a query is
// computed; loads are taken back to back. The result sits in an output
// register, so a stalled receiver by itself does not block loads; it holds up
// the next query's completion, and the input then stays not ready until that
// query's result can be loaded. Reset empties the set and the output register;
// the sample RAM is not cleared and needs no sweep.
module weighted_circular_autocorrelation import wca_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  input  logic [((RADIUS_BITS+LAG_W+7)/8)*8-1:0]        s_axis_tdata,  // radius, lag
  input  logic                                          s_axis_tuser,  // command
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  output logic [EPS_W-1:0]                              m_axis_tdata,  // epsilon
  output logic [ERR_W-1:0]                              m_axis_tuser   // error
);

  localparam int CW   = $clog2(MAX_SAMPLES+1);
  localparam int IW   = $clog2(MAX_SAMPLES);
  localparam int SW   = RADIUS_BITS + $clog2(3*MAX_SAMPLES);
  localparam int CMPW = (CW > LAG_W) ? CW : LAG_W;

  logic [RADIUS_BITS-1:0] radius;
  logic [LAG_W-1:0]       lag;
  logic                   accept, do_load, do_query;

  logic [CW-1:0]  count_q, count_eff;
  logic [SW-1:0]  sum_q, sum_eff;
  logic           queried_q, ovf_q, ovf_eff, full;
  logic           busy_q, early_q;
  logic [ERR_W-1:0] err_q;
  logic           early_err;
  logic [ERR_W-1:0] early_code;

  logic             out_v_q;
  logic [EPS_W-1:0] out_eps_q;
  logic [ERR_W-1:0] out_err_q;
  logic             out_free, res_ready, res_load;

  corr_req_t req;
  corr_res_t res;
  logic [IW-1:0]          raddr_a, raddr_b;
  logic [RADIUS_BITS-1:0] rdata_a, rdata_b;

  assign radius   = s_axis_tdata[RADIUS_BITS-1:0];
  assign lag      = s_axis_tdata[RADIUS_BITS+LAG_W-1:RADIUS_BITS];
  assign s_axis_tready = !busy_q;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign do_load  = accept && (s_axis_tuser == CMD_LOAD);
  assign do_query = accept && (s_axis_tuser == CMD_QUERY);

  assign count_eff = queried_q ? '0 : count_q;
  assign sum_eff   = queried_q ? '0 : sum_q;
  assign ovf_eff   = queried_q ? 1'b0 : ovf_q;
  assign full      = (count_eff == CW'(MAX_SAMPLES));

  always_comb begin
    early_err  = 1'b1;
    early_code = ERR_RANGE;
    if (count_q == '0 || CMPW'(lag) >= CMPW'(count_q)) begin
      early_code = ERR_RANGE;
    end else if (sum_q == '0) begin
      early_code = ERR_ZERO_AVG;
    end else begin
      early_err  = 1'b0;
      early_code = ovf_q ? ERR_OVERFLOW : ERR_OK;
    end
  end

  assign req.start = do_query && !early_err;
  assign req.lag   = lag;

  assign out_free  = !out_v_q || m_axis_tready;
  assign res_ready = early_q || res.valid;
  assign res_load  = busy_q && res_ready && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      queried_q <= 1'b0;
      ovf_q     <= 1'b0;
      busy_q    <= 1'b0;
      early_q   <= 1'b0;
      err_q     <= ERR_OK;
      out_v_q   <= 1'b0;
    end else begin
      if (do_load) begin
        queried_q <= 1'b0;
        if (full) begin
          count_q <= count_eff;
          sum_q   <= sum_eff;
          ovf_q   <= 1'b1;
        end else begin
          count_q <= count_eff + 1'b1;
          sum_q   <= sum_eff + (count_eff[0] ? (SW'(radius) << 2) : (SW'(radius) << 1));
          ovf_q   <= ovf_eff;
        end
      end
      if (do_query) begin
        queried_q <= 1'b1;
        busy_q    <= 1'b1;
        early_q   <= early_err;
        err_q     <= early_code;
      end else if (res_load) begin
        busy_q  <= 1'b0;
        early_q <= 1'b0;
      end
      if (res_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_eps_q <= early_q ? '0 : res.eps;
      out_err_q <= err_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_eps_q;
  assign m_axis_tuser  = out_err_q;

  wca_ram #(
    .Width (RADIUS_BITS),
    .Depth (MAX_SAMPLES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (do_load && !full),
    .waddr_i   (count_eff[IW-1:0]),
    .wdata_i   (radius),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  wca_corr #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_corr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .count_i   (count_q),
    .sum_i     (sum_q),
    .ack_i     (res_load && !early_q),
    .res_o     (res),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b)
  );

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("sample count beyond capacity");
  a_set_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && $past(busy_q) |-> $stable(count_q) && $stable(sum_q))
    else $error("set changed during a query");
  a_out_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> busy_q && !s_axis_tready)
    else $error("result loaded without a pending query");
`endif

endmodule

>>> tb/tb_weighted_circular_autocorrelation.sv
// Testbench for weighted_circular_autocorrelation: random sample sets checked against a predictor.
`timescale 1ns / 1ps

module tb_weighted_circular_autocorrelation;
  import wca_pkg::*;

  localparam int IN_W           = ((RADIUS_BITS_DEF + LAG_W + 7) / 8) * 8;
  localparam int RADIUS_MAX     = (1 << RADIUS_BITS_DEF) - 1;
  localparam int LAG_MAX        = (1 << LAG_W) - 1;
  localparam int WEIGHT_EVEN    = 2;
  localparam int WEIGHT_ODD     = 4;
  localparam int AVG_DIV        = 3;
  localparam int RANDOM_ITEMS   = 540;
  localparam int QUIET_ITEMS    = 80;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES    = 200;
  localparam longint TIMEOUT_NS = 6_000_000;

  typedef struct packed {
    logic                       drain;
    logic                       kick;
    logic                       cmd;
    logic [RADIUS_BITS_DEF-1:0] radius;
    logic [LAG_W-1:0]           lag;
  } stream_cmd_t;

  typedef struct packed {
    logic [EPS_W-1:0] eps;
    logic [ERR_W-1:0] err;
  } corr_result_t;

  typedef enum int {
    FILL_FULL, FILL_NEAR, FILL_ZERO, FILL_SPIKE, FILL_TINY, FILL_ALT, FILL_MAX
  } fill_mode_e;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [EPS_W-1:0] m_axis_tdata;
  logic [ERR_W-1:0] m_axis_tuser;

  weighted_circular_autocorrelation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  stream_cmd_t  stream_cmd_q[$];
  corr_result_t expected_eps_q[$];

  // predictor state
  logic [RADIUS_BITS_DEF-1:0] radius_store [MAX_SAMPLES_DEF];
  int     set_count   = 0;
  longint set_wsum    = 0;
  logic   set_queried = 1'b0;
  logic   set_ovf     = 1'b0;

  // stimulus generation state
  int   gen_n           = 0;
  logic gen_after_query = 1'b0;
  int   gen_items       = 0;

  stream_cmd_t  tx_cur;
  corr_result_t rx_want;
  logic in_fire     = 1'b0;
  logic quiet       = 1'b0;
  logic hold_kick   = 1'b0;
  logic rx_hold     = 1'b0;
  int   tx_gap      = 0;
  int   tx_idle_pct = 10;
  int   tx_sent     = 0;
  int   rx_gap      = 0;
  int   rx_idle_pct = 10;
  int   rx_cycle    = 0;

  int items_total    = 0;
  int items_accepted = 0;
  int n_loads        = 0;
  int n_queries      = 0;
  int n_checked      = 0;
  int mismatches     = 0;
  int largest_set    = 0;
  int n_saturated    = 0;
  int err_seen [4]   = '{0, 0, 0, 0};

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic corr_result_t predict_autocorr(input logic [LAG_W-1:0] lag_v);
    corr_result_t      res;
    longint            a3, s, da, dk, prod;
    logic signed [95:0] acc, term;
    logic [127:0]      mag, num, den, quo, rmd;
    int                idx;
    res.eps = '0;
    res.err = ERR_OK;
    if (set_count == 0 || lag_v >= set_count) begin
      res.err = ERR_RANGE;
    end else if (set_wsum == 0) begin
      res.err = ERR_ZERO_AVG;
    end else begin
      a3  = AVG_DIV * set_count;
      s   = set_wsum;
      acc = '0;
      for (int k = 0; k < set_count; k++) begin
        idx = k + lag_v + 1;
        if (idx >= set_count) idx = idx - set_count;
        da   = a3 * radius_store[idx] - s;
        dk   = a3 * radius_store[k] - s;
        prod = da * dk;
        prod = (k % 2) ? prod * WEIGHT_ODD : prod * WEIGHT_EVEN;
        term = prod;
        acc  = acc + term;
      end
      mag = {32'b0, (acc[95] ? -acc : acc)};
      num = mag << FRAC_BITS;
      den = s;
      den = den * s * a3;
      quo = num / den;
      rmd = num % den;
      if ((rmd << 1) >= den) quo = quo + 1;
      if (acc[95]) begin
        if (quo > 128'h8000_0000) res.eps = EPS_NEG_MIN;
        else res.eps = 32'd0 - quo[31:0];
      end else begin
        if (quo > 128'h7FFF_FFFF) res.eps = EPS_POS_MAX;
        else res.eps = quo[31:0];
      end
      res.err = set_ovf ? ERR_OVERFLOW : ERR_OK;
    end
    return res;
  endfunction

  task automatic push_cmd(input logic cmd, input int value, input logic drain,
                          input logic kick);
    stream_cmd_t item;
    item.drain = drain;
    item.kick  = kick;
    item.cmd   = cmd;
    if (cmd == CMD_LOAD) begin
      item.radius = value;
      item.lag    = $urandom_range(0, LAG_MAX);
      if (gen_after_query) begin
        gen_n           = 0;
        gen_after_query = 1'b0;
      end
      if (gen_n < MAX_SAMPLES_DEF) gen_n++;
    end else begin
      item.radius     = $urandom_range(0, RADIUS_MAX);
      item.lag        = value;
      gen_after_query = 1'b1;
    end
    stream_cmd_q.push_back(item);
    gen_items++;
  endtask

  task automatic add_set(input int n, input fill_mode_e mode, input logic drain_first);
    int base;
    int spike_at;
    int r;
    base     = $urandom_range(0, RADIUS_MAX - 2048);
    spike_at = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      case (mode)
        FILL_FULL:  r = $urandom_range(0, RADIUS_MAX);
        FILL_NEAR:  r = base + $urandom_range(0, 2047);
        FILL_ZERO:  r = 0;
        FILL_SPIKE: r = (k == spike_at) ? $urandom_range(1, RADIUS_MAX) : 0;
        FILL_TINY:  r = $urandom_range(0, 3);
        FILL_ALT:   r = (k % 2) ? RADIUS_MAX - $urandom_range(0, 15) : $urandom_range(0, 15);
        default:    r = RADIUS_MAX;
      endcase
      push_cmd(CMD_LOAD, r, drain_first && k == 0, 1'b0);
    end
  endtask

  task automatic add_queries(input int count, input logic drain_first, input logic kick_first);
    int pick;
    int lag_v;
    for (int q = 0; q < count; q++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) lag_v = gen_n - 1;
      else if (pick < 30) lag_v = 0;
      else if (pick < 75 || gen_n >= MAX_SAMPLES_DEF) lag_v = $urandom_range(0, gen_n - 1);
      else lag_v = $urandom_range(gen_n, LAG_MAX);
      push_cmd(CMD_QUERY, lag_v, drain_first && q == 0, kick_first && q == 0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (stream_cmd_q.size() == 0 ||
                   (stream_cmd_q[0].drain && expected_eps_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
        tx_gap = $urandom_range(0, 10);
        s_axis_tvalid <= 1'b0;
      end else begin
        tx_cur = stream_cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - RADIUS_BITS_DEF - LAG_W){1'b0}}, tx_cur.lag, tx_cur.radius};
        s_axis_tuser  <= tx_cur.cmd;
        tx_sent++;
        if (tx_sent % 64 == 0) tx_idle_pct = pick_idle_pct();
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_idle_pct = pick_idle_pct();
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap = rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap = $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // long receiver hold-off while queries keep coming
  initial begin
    wait (hold_kick);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    quiet <= (stream_cmd_q.size() < QUIET_ITEMS);
  end

  // input transactions: update predictor state
  always @(posedge clk_i) begin
    corr_result_t res;
    logic [RADIUS_BITS_DEF-1:0] r;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      items_accepted++;
      if (tx_cur.kick) hold_kick = 1'b1;
      if (s_axis_tuser == CMD_LOAD) begin
        n_loads++;
        r = s_axis_tdata[RADIUS_BITS_DEF-1:0];
        if (set_queried) begin
          set_count   = 0;
          set_wsum    = 0;
          set_ovf     = 1'b0;
          set_queried = 1'b0;
        end
        if (set_count >= MAX_SAMPLES_DEF) begin
          set_ovf = 1'b1;
        end else begin
          radius_store[set_count] = r;
          set_wsum = set_wsum + ((set_count % 2) ? WEIGHT_ODD : WEIGHT_EVEN) * r;
          set_count++;
        end
      end else begin
        n_queries++;
        res = predict_autocorr(s_axis_tdata[RADIUS_BITS_DEF +: LAG_W]);
        set_queried = 1'b1;
        if (set_count > largest_set) largest_set = set_count;
        err_seen[res.err]++;
        if ((res.err == ERR_OK || res.err == ERR_OVERFLOW) &&
            (res.eps == EPS_POS_MAX || res.eps == EPS_NEG_MIN)) n_saturated++;
        expected_eps_q.push_back(res);
      end
    end
  end

  // output transactions: compare with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (expected_eps_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: eps %h err %0d with nothing outstanding",
                   m_axis_tdata, m_axis_tuser);
      end else begin
        rx_want = expected_eps_q.pop_front();
        if (m_axis_tdata !== rx_want.eps || m_axis_tuser !== rx_want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on result %0d: expected eps %h err %0d, got eps %h err %0d",
                     n_checked, rx_want.eps, rx_want.err, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    int         pick;
    int         set_n;
    int         dir_items;
    int         big_items;
    int         mark;
    logic       stall_done;
    logic       ovf_done;
    fill_mode_e mode;
    stall_done = 1'b0;
    ovf_done   = 1'b0;
    big_items  = 0;

    // directed: empty set, zero average, out of range, single sample, extremes
    push_cmd(CMD_QUERY, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 0, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 1, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, RADIUS_MAX, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 0, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, LAG_MAX, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, RADIUS_MAX, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 3, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, RADIUS_MAX, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, 0, 1'b0, 1'b0);
    push_cmd(CMD_LOAD, RADIUS_MAX, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 0, 1'b0, 1'b0);
    push_cmd(CMD_QUERY, 1, 1'b0, 1'b0);
    dir_items = gen_items;

    while (gen_items - dir_items - big_items < RANDOM_ITEMS) begin
      if (!stall_done && gen_items - dir_items - big_items >= RANDOM_ITEMS / 4) begin
        add_set(12, FILL_NEAR, 1'b1);
        add_queries(5, 1'b1, 1'b1);
        stall_done = 1'b1;
      end else if (!ovf_done && gen_items - dir_items - big_items >= RANDOM_ITEMS / 2) begin
        mark = gen_items;
        add_set(MAX_SAMPLES_DEF + $urandom_range(1, 6), FILL_NEAR, 1'b1);
        push_cmd(CMD_QUERY, LAG_MAX, 1'b0, 1'b0);
        push_cmd(CMD_QUERY, 0, 1'b0, 1'b0);
        add_queries(2, 1'b0, 1'b0);
        big_items = gen_items - mark;
        ovf_done  = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) set_n = $urandom_range(1, 16);
        else if (pick < 90) set_n = $urandom_range(17, 64);
        else set_n = $urandom_range(65, 200);
        pick = $urandom_range(0, 99);
        if (pick < 25) mode = FILL_FULL;
        else if (pick < 55) mode = FILL_NEAR;
        else if (pick < 62) mode = FILL_ZERO;
        else if (pick < 72) mode = FILL_SPIKE;
        else if (pick < 82) mode = FILL_TINY;
        else if (pick < 92) mode = FILL_ALT;
        else mode = FILL_MAX;
        add_set(set_n, mode, $urandom_range(0, 7) == 0);
        add_queries($urandom_range(1, 5), 1'b0, 1'b0);
      end
    end
    items_total = gen_items;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted != items_total || expected_eps_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d loads and %0d queries, sets of up to %0d samples, %0d saturated",
             n_loads, n_queries, largest_set, n_saturated);
    $display("Results: %0d ok, %0d range, %0d zero average, %0d overflowed; %0d mismatches",
             err_seen[ERR_OK], err_seen[ERR_RANGE], err_seen[ERR_ZERO_AVG],
             err_seen[ERR_OVERFLOW], mismatches);
    if (mismatches == 0) begin
      $display("tb_weighted_circular_autocorrelation passed");
    end else begin
      $display("tb_weighted_circular_autocorrelation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_weighted_circular_autocorrelation failed");
    $finish;
  end

endmodule
